FILE: sv/linked_list_set_table_defines.svh
// Assertion macros for the linked list set table.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LINKED_LIST_SET_TABLE_DEFINES_SVH
`define LINKED_LIST_SET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset
`define LLST_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define LLST_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define LLST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LLST_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define LLST_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define LLST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/llst_pkg.sv
// Shared constants, codes and control types for the linked list set table.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package llst_pkg;

   // Store geometry
   localparam int CAPACITY   = 128;
   localparam int VALUE_BITS = 32;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int LINK_BITS  = $clog2(CAPACITY + 1);
   localparam int COUNT_BITS = 8;
   localparam int OP_BITS    = 2;
   localparam int RSP_BITS   = 16;

   // Null link code sits just past the last slot
   localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(CAPACITY);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(CAPACITY - 1);

   // Operation codes carried in the request
   typedef enum logic [OP_BITS-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2
   } llst_op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WALK,
      ST_ADD_READ,
      ST_ADD_WRITE,
      ST_UNLINK,
      ST_RELEASE,
      ST_REPLY
   } llst_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic start_walk;
      logic walk_step;
      logic read_free;
      logic add_commit;
      logic unlink;
      logic release_slot;
      logic rsp_load;
      logic rsp_ok;
      logic rsp_full;
   } llst_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               head_null;
      logic               free_null;
      logic               match;
      logic               walk_more;
      logic               rsp_free;
   } llst_status_type;

endpackage

`default_nettype wire

FILE: sv/linked_list_set_table.sv
// Top level of the linked list set table: ties the controller to the datapath.
// Depends on llst_pkg, llst_ctrl and llst_datapath.
//
//   channel   direction  ports               contents
//   req       in         req_t*  tdata/tuser  tdata[31:0] value, tuser[1:0] op
//   rsp       out        rsp_t*  tdata        success, store_full, count, empty
//
// A request walks the list one node per cycle from a registered memory read,
// visiting at most 128 nodes with 128 slots. A successful add then reads the
// free slot and commits it; a successful remove unlinks and releases the node.
// Reset is synchronous; the link store needs no clearing pass, per-slot init
// bits supply the initial free chain. One request is in flight at a time; the
// result register lets a waiting result sit while the next request is taken.
`default_nettype none

module linked_list_set_table (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [31:0] value
   input  wire  [llst_pkg::VALUE_BITS-1:0]    req_tdata,
   // [1:0] op
   input  wire  [llst_pkg::OP_BITS-1:0]       req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [0] success, [1] store_full, [9:2] element_count, [10] set_empty, [15:11] zero
   output logic [llst_pkg::RSP_BITS-1:0]      rsp_tdata
);
   import llst_pkg::*;

   llst_cmd_type    cmd;
   llst_status_type status;

   // Sequencer
   llst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Storage and result register
   llst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: sv/llst_ctrl.sv
// Sequencing state machine for the linked list set table.
// Depends on llst_pkg for the state enum, op codes and command/status structs.
`default_nettype none

module llst_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  llst_pkg::llst_status_type status,
   output llst_pkg::llst_cmd_type    cmd
);
   import llst_pkg::*;

   llst_state_type state_ff, state_in;
   logic           ok_ff, ok_in;
   logic           full_ff, full_in;
   logic           op_valid;
   logic           op_add;
   logic           op_remove;
   logic           miss;

   assign op_add    = (status.op == OP_ADD);
   assign op_remove = (status.op == OP_REMOVE);
   assign op_valid  = op_add || op_remove || (status.op == OP_SEARCH);

   // Walk ends without a hit: empty list, or tail reached with no match
   assign miss = ((state_ff == ST_LOOKUP) && op_valid && status.head_null) ||
                 ((state_ff == ST_WALK) && !status.match && !status.walk_more);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (!op_valid) state_in = ST_REPLY;
            else if (status.head_null) begin
               state_in = (op_add && !status.free_null) ? ST_ADD_READ : ST_REPLY;
            end else state_in = ST_WALK;
         end
         ST_WALK: begin
            if (status.match) begin
               state_in = op_remove ? ST_UNLINK : ST_REPLY;
            end else if (!status.walk_more) begin
               state_in = (op_add && !status.free_null) ? ST_ADD_READ : ST_REPLY;
            end
         end
         ST_ADD_READ:  state_in = ST_ADD_WRITE;
         ST_ADD_WRITE: state_in = ST_REPLY;
         ST_UNLINK:    state_in = ST_RELEASE;
         ST_RELEASE:   state_in = ST_REPLY;
         ST_REPLY: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result flags: clear per request, set at the deciding step
   always_comb begin
      ok_in   = ok_ff;
      full_in = full_ff;
      if (state_ff == ST_IDLE) begin
         ok_in   = 1'b0;
         full_in = 1'b0;
      end
      if (state_ff == ST_ADD_WRITE) ok_in = 1'b1;
      if ((state_ff == ST_WALK) && status.match && !op_add) ok_in = 1'b1;
      if (miss && op_add && status.free_null) full_in = 1'b1;
   end

   // Outputs
   always_comb begin
      cmd              = '0;
      cmd.load_req     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.start_walk   = (state_ff == ST_LOOKUP) && op_valid && !status.head_null;
      cmd.walk_step    = (state_ff == ST_WALK) && !status.match && status.walk_more;
      cmd.read_free    = (state_ff == ST_ADD_READ);
      cmd.add_commit   = (state_ff == ST_ADD_WRITE);
      cmd.unlink       = (state_ff == ST_UNLINK);
      cmd.release_slot = (state_ff == ST_RELEASE);
      cmd.rsp_load     = (state_ff == ST_REPLY) && status.rsp_free;
      cmd.rsp_ok       = ok_ff;
      cmd.rsp_full     = full_ff;
      req_tready       = (state_ff == ST_IDLE);
   end

   // State and flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         full_ff  <= full_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/llst_datapath.sv
// Datapath for the linked list set table: value and link memories, list and
// free-chain heads, walk pointers and the result register. Depends on llst_pkg.
`default_nettype none

`include "linked_list_set_table_defines.svh"

module llst_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [llst_pkg::OP_BITS-1:0]      req_op,
   input  wire  [llst_pkg::VALUE_BITS-1:0]   req_value,
   input  llst_pkg::llst_cmd_type            cmd,
   output llst_pkg::llst_status_type         status,
   input  wire                               rsp_tready,
   output logic                              rsp_tvalid,
   output logic [llst_pkg::RSP_BITS-1:0]     rsp_tdata
);
   import llst_pkg::*;

   // Request payload
   logic [OP_BITS-1:0]    op_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // List bookkeeping
   logic [LINK_BITS-1:0]  head_ff, head_in;
   logic [LINK_BITS-1:0]  free_ff, free_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Walk pointers
   logic [LINK_BITS-1:0]  cur_ff;
   logic [LINK_BITS-1:0]  prev_ff;
   logic [SLOT_BITS-1:0]  steps_ff;

   // Memories and read port
   logic [VALUE_BITS-1:0] value_mem_ff [CAPACITY];
   logic [LINK_BITS-1:0]  link_mem_ff  [CAPACITY];
   logic [CAPACITY-1:0]   link_init_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;
   logic [LINK_BITS-1:0]  link_rd_ff;
   logic [SLOT_BITS-1:0]  rd_slot_ff;
   logic                  rd_init_ff;
   logic                  rd_en;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic [LINK_BITS-1:0]  link_eff;

   // Link write port
   logic                  link_we;
   logic [SLOT_BITS-1:0]  link_waddr;
   logic [LINK_BITS-1:0]  link_wdata;

   // Result register
   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic                  rsp_full_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_empty_ff;

   // Unwritten link entries read as their reset chain value
   always_comb begin
      if (rd_init_ff) link_eff = link_rd_ff;
      else if (rd_slot_ff == LAST_SLOT) link_eff = NULL_LINK;
      else link_eff = {1'b0, rd_slot_ff} + LINK_BITS'(1);
   end

   // Read address select
   always_comb begin
      rd_en   = cmd.start_walk || cmd.walk_step || cmd.read_free;
      rd_addr = head_ff[SLOT_BITS-1:0];
      if (cmd.walk_step) rd_addr = link_eff[SLOT_BITS-1:0];
      if (cmd.read_free) rd_addr = free_ff[SLOT_BITS-1:0];
   end

   // Link write select: new node, predecessor bypass, or freed slot
   always_comb begin
      link_we    = 1'b0;
      link_waddr = free_ff[SLOT_BITS-1:0];
      link_wdata = head_ff;
      if (cmd.add_commit) begin
         link_we = 1'b1;
      end
      if (cmd.unlink && (prev_ff != NULL_LINK)) begin
         link_we    = 1'b1;
         link_waddr = prev_ff[SLOT_BITS-1:0];
         link_wdata = link_eff;
      end
      if (cmd.release_slot) begin
         link_we    = 1'b1;
         link_waddr = cur_ff[SLOT_BITS-1:0];
         link_wdata = free_ff;
      end
   end

   // Head, free chain and count updates
   always_comb begin
      head_in  = head_ff;
      free_in  = free_ff;
      count_in = count_ff;
      if (cmd.add_commit) begin
         free_in  = link_eff;
         head_in  = free_ff;
         count_in = count_ff + COUNT_BITS'(1);
      end
      if (cmd.unlink && (prev_ff == NULL_LINK)) head_in = link_eff;
      if (cmd.release_slot) begin
         free_in = cur_ff;
         if (count_ff != '0) count_in = count_ff - COUNT_BITS'(1);
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.add_commit) value_mem_ff[free_ff[SLOT_BITS-1:0]] <= value_ff;
      if (rd_en) value_rd_ff <= value_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem_ff[link_waddr] <= link_wdata;
      if (rd_en) begin
         link_rd_ff <= link_mem_ff[rd_addr];
         rd_slot_ff <= rd_addr;
         rd_init_ff <= link_init_ff[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NULL_LINK;
         free_ff      <= '0;
         count_ff     <= '0;
         link_init_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         free_ff  <= free_in;
         count_ff <= count_in;
         if (link_we) link_init_ff[link_waddr] <= 1'b1;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Request latch, walk pointers and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      if (cmd.start_walk) begin
         cur_ff   <= head_ff;
         prev_ff  <= NULL_LINK;
         steps_ff <= '0;
      end
      if (cmd.walk_step) begin
         prev_ff  <= cur_ff;
         cur_ff   <= link_eff;
         steps_ff <= steps_ff + SLOT_BITS'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= cmd.rsp_ok;
         rsp_full_ff  <= cmd.rsp_full;
         rsp_count_ff <= count_ff;
         rsp_empty_ff <= (head_ff == NULL_LINK);
      end
   end

   // Status back to the controller
   always_comb begin
      status.op        = op_ff;
      status.head_null = (head_ff == NULL_LINK);
      status.free_null = (free_ff == NULL_LINK);
      status.match     = (value_rd_ff == value_ff);
      status.walk_more = (link_eff != NULL_LINK) && (steps_ff != LAST_SLOT);
      status.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS - COUNT_BITS - 3){1'b0}}, rsp_empty_ff, rsp_count_ff,
                        rsp_full_ff, rsp_ok_ff};

   // Empty list and zero count go together, except in the step that frees a removed slot
   `LLST_ASSERT_IMPLY(a_head_count, clock, reset, !cmd.release_slot, (head_ff == NULL_LINK) == (count_ff == '0), "list head and element count disagree")
   // A slot is only taken from a non-empty free chain
   `LLST_ASSERT_IMPLY(a_add_free, clock, reset, cmd.add_commit, free_ff != NULL_LINK, "add commit with empty free chain")
   // A released slot becomes the free chain head
   `LLST_ASSERT_NEXT(a_release_head, clock, reset, cmd.release_slot, free_ff == $past(cur_ff), "released slot not at free chain head")
   // A result is never overwritten while still waiting
   `LLST_ASSERT_IMPLY(a_rsp_hold, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_tready, "result register overwritten")

endmodule

`default_nettype wire
